@@ rtl/lipl_pkg.sv @@
// ----------------------------------------------------------------------------
// lipl_pkg
// Shared types and constants for the line index and position lookup unit.
// ----------------------------------------------------------------------------
package lipl_pkg;

   localparam int MAX_LINES     = 1024;
   localparam int LINE_BITS     = $clog2(MAX_LINES);
   localparam int TOTAL_BITS    = LINE_BITS + 1;
   localparam int POS_BITS      = 16;
   localparam int POS_CNT_BITS  = POS_BITS + 1;
   localparam int LINE_NUM_BITS = 17;
   localparam int CHAR_BITS     = 8;

   localparam logic [CHAR_BITS-1:0] CHAR_CR = 8'd13;
   localparam logic [CHAR_BITS-1:0] CHAR_LF = 8'd10;

   localparam logic [TOTAL_BITS-1:0]   TOTAL_LIMIT = TOTAL_BITS'(MAX_LINES);
   localparam logic [POS_CNT_BITS-1:0] POS_LIMIT   = POS_CNT_BITS'(1) << POS_BITS;

   typedef enum logic [1:0] {
      CMD_CHAR  = 2'd0,
      CMD_END   = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_EARLY    = 2'd1,
      STAT_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SEEK = 4'b0010,
      ST_CMP  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

endpackage

@@ rtl/lipl_ram.sv @@
// ----------------------------------------------------------------------------
// lipl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lipl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/line_index_and_position_lookup_unit.sv @@
// ----------------------------------------------------------------------------
// line_index_and_position_lookup_unit
// Builds a table of line starts from a character stream, then maps query
// positions to line number and column by binary search over the table.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  req_     in   req_tvalid/tready     tuser: cmd; tdata: char_code, query_position
//  rsp_     out  rsp_tvalid/tready     tuser: status; tdata: line_number, column_number
//  csr_     in   csr_valid/csr_ready   data: line_number_offset
//
//  Character and end-of-text transactions: result registered in the cycle after
//  acceptance. Queries: up to LINE_BITS search steps, each a SEEK state reading
//  the single table read port (registered read) and a CMP state, then DONE.
//  One transaction in flight at a time; a new one is taken as the result leaves.
//  Synchronous reset clears all control state; the table needs no clearing.
// ----------------------------------------------------------------------------
module line_index_and_position_lookup_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   input  logic [23:0] req_tdata,   // [7:0] char_code, [23:8] query_position
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic [39:0] rsp_tdata,   // [16:0] line_number, [32:17] column_number, zero above
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam int TB  = lipl_pkg::TOTAL_BITS;
   localparam int PB  = lipl_pkg::POS_BITS;
   localparam int PCB = lipl_pkg::POS_CNT_BITS;
   localparam int LNB = lipl_pkg::LINE_NUM_BITS;

   lipl_pkg::state_type state_ff, state_in;

   logic [TB-1:0]  total_ff, total_in;
   logic [PCB-1:0] pos_ff, pos_in;
   logic [PCB-1:0] begin_ff, begin_in;
   logic           after_cr_ff, after_cr_in;
   logic           finished_ff, finished_in;
   logic [15:0]    offset_ff;

   logic [TB-1:0]  s_ff, s_in;
   logic [TB-1:0]  e_ff, e_in;
   logic [TB-1:0]  m_ff, m_in;
   logic [PB-1:0]  s_val_ff, s_val_in;
   logic [PB-1:0]  qpos_ff, qpos_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [LNB-1:0] rsp_line_ff, rsp_line_in;
   logic [PB-1:0]  rsp_col_ff, rsp_col_in;
   logic [1:0]     rsp_stat_ff, rsp_stat_in;

   logic                            wr_en;
   logic [lipl_pkg::LINE_BITS-1:0]  rd_addr;
   logic [PB-1:0]                   rd_data;
   logic [TB-1:0]                   span;
   logic [TB-1:0]                   mid;

   logic [1:0]                      cmd;
   logic [lipl_pkg::CHAR_BITS-1:0]  ch;
   logic [PB-1:0]                   qpos;
   logic                            accept;
   logic                            rsp_free;
   logic                            table_full;
   logic                            is_term;

   assign cmd  = req_tuser;
   assign ch   = req_tdata[7:0];
   assign qpos = req_tdata[23:8];

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == lipl_pkg::ST_IDLE) && rsp_free;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign table_full = (total_ff >= lipl_pkg::TOTAL_LIMIT);
   assign is_term    = (ch == lipl_pkg::CHAR_CR) || (ch == lipl_pkg::CHAR_LF);

   assign span = e_ff - s_ff;
   assign mid  = s_ff + (span >> 1);

   lipl_ram #(
      .WIDTH (PB),
      .DEPTH (lipl_pkg::MAX_LINES)
   ) u_line_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (total_ff[lipl_pkg::LINE_BITS-1:0]),
      .wr_data (begin_ff[PB-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      pos_in       = pos_ff;
      begin_in     = begin_ff;
      after_cr_in  = after_cr_ff;
      finished_in  = finished_ff;
      s_in         = s_ff;
      e_in         = e_ff;
      m_in         = m_ff;
      s_val_in     = s_val_ff;
      qpos_in      = qpos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_line_in  = rsp_line_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_stat_in  = rsp_stat_ff;
      wr_en        = 1'b0;
      rd_addr      = m_ff[lipl_pkg::LINE_BITS-1:0];

      unique case (state_ff)
         lipl_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_line_in = '0;
               rsp_col_in  = '0;
               rsp_stat_in = lipl_pkg::STAT_OK;
               rsp_valid_in = 1'b1;
               priority if (cmd == lipl_pkg::CMD_CHAR && !finished_ff) begin
                  priority if (pos_ff >= lipl_pkg::POS_LIMIT) begin
                     rsp_stat_in = lipl_pkg::STAT_OVERFLOW;
                  end else if (after_cr_ff && ch == lipl_pkg::CHAR_LF) begin
                     pos_in      = pos_ff + 1'b1;
                     begin_in    = pos_ff + 1'b1;
                     after_cr_in = 1'b0;
                  end else if (is_term) begin
                     if (!table_full) begin
                        wr_en       = 1'b1;
                        total_in    = total_ff + 1'b1;
                        pos_in      = pos_ff + 1'b1;
                        begin_in    = pos_ff + 1'b1;
                        after_cr_in = (ch == lipl_pkg::CHAR_CR);
                     end else begin
                        rsp_stat_in = lipl_pkg::STAT_OVERFLOW;
                     end
                  end else begin
                     pos_in      = pos_ff + 1'b1;
                     after_cr_in = 1'b0;
                  end
               end else if (cmd == lipl_pkg::CMD_END && !finished_ff) begin
                  // open last line without terminator
                  if (pos_ff != begin_ff) begin
                     if (!table_full) begin
                        wr_en    = 1'b1;
                        total_in = total_ff + 1'b1;
                     end else begin
                        rsp_stat_in = lipl_pkg::STAT_OVERFLOW;
                     end
                  end
                  finished_in = 1'b1;
                  after_cr_in = 1'b0;
               end else if (cmd == lipl_pkg::CMD_QUERY) begin
                  if (!finished_ff) begin
                     rsp_stat_in = lipl_pkg::STAT_EARLY;
                  end else begin
                     // entry 0 always starts at position 0
                     rsp_valid_in = 1'b0;
                     s_in         = '0;
                     e_in         = total_ff;
                     s_val_in     = '0;
                     qpos_in      = qpos;
                     state_in     = lipl_pkg::ST_SEEK;
                  end
               end else begin
               end
            end
         end
         lipl_pkg::ST_SEEK: begin
            rd_addr = mid[lipl_pkg::LINE_BITS-1:0];
            m_in    = mid;
            if (span > TB'(1)) begin
               state_in = lipl_pkg::ST_CMP;
            end else begin
               state_in = lipl_pkg::ST_DONE;
            end
         end
         lipl_pkg::ST_CMP: begin
            if (rd_data > qpos_ff) begin
               e_in = m_ff;
            end else begin
               s_in     = m_ff;
               s_val_in = rd_data;
            end
            state_in = lipl_pkg::ST_SEEK;
         end
         lipl_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_line_in  = {{(LNB-TB){1'b0}}, s_ff} + {{(LNB-16){1'b0}}, offset_ff};
               rsp_col_in   = qpos_ff - s_val_ff;
               rsp_stat_in  = lipl_pkg::STAT_OK;
               state_in     = lipl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lipl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lipl_pkg::ST_IDLE;
         total_ff     <= '0;
         pos_ff       <= '0;
         begin_ff     <= '0;
         after_cr_ff  <= 1'b0;
         finished_ff  <= 1'b0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         pos_ff       <= pos_in;
         begin_ff     <= begin_in;
         after_cr_ff  <= after_cr_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            offset_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      s_ff        <= s_in;
      e_ff        <= e_in;
      m_ff        <= m_in;
      s_val_ff    <= s_val_in;
      qpos_ff     <= qpos_in;
      rsp_line_ff <= rsp_line_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tdata  = {7'd0, rsp_col_ff, rsp_line_ff};

   // ------------------------------------------------------------------------
   // assertions
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= lipl_pkg::TOTAL_LIMIT)
      else $error("line count beyond table depth");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= lipl_pkg::POS_LIMIT)
      else $error("character position beyond text limit");

   a_probe_inside: assert property (@(posedge clock) disable iff (reset)
      state_ff == lipl_pkg::ST_CMP |-> (s_ff < m_ff) && (m_ff < e_ff))
      else $error("search probe outside current interval");

   a_search_closed: assert property (@(posedge clock) disable iff (reset)
      state_ff == lipl_pkg::ST_DONE |-> (e_ff - s_ff) <= TB'(1))
      else $error("search finished with open interval");

endmodule
